// ===== sv/fts_pkg.sv =====
// shared constants, types and state encodings of the flex and touch conditioner
`default_nettype none

package fts_pkg;

  localparam int SAMPW = 10;
  localparam int ANGW = 7;
  localparam int NCH = 3;
  localparam int TOUCHW = 3;
  localparam int MAX_DEG = 90;
  localparam int NREG = 6;
  localparam int REG_IDX_W = 3;

  localparam int DEF_FLEX_WINDOW = 10;
  localparam int DEF_TOUCH_WINDOW = 3;

  localparam logic [SAMPW-1:0] CAL_RESET [NREG] = '{
    10'd900, 10'd1023, 10'd850, 10'd960, 10'd890, 10'd965
  };

  localparam int BEND_LIMIT_TAB [NCH] = '{60, 77, 70};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAL_LOW_A  = 3'd0,
    REG_CAL_HIGH_A = 3'd1,
    REG_CAL_LOW_B  = 3'd2,
    REG_CAL_HIGH_B = 3'd3,
    REG_CAL_LOW_C  = 3'd4,
    REG_CAL_HIGH_C = 3'd5
  } fts_reg_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_UPD,
    L_AVG,
    L_MAP,
    L_ANG,
    L_FIN,
    L_DONE
  } lane_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CALC,
    T_HOLD
  } top_state_e;

  // per-item control handed from the sequencer to every lane
  typedef struct packed {
    logic start;
    logic seeded;
    logic fill;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/fts_if.sv =====
// input and output channel interfaces of the flex and touch conditioner
`default_nettype none

interface fts_in_if;
  import fts_pkg::*;

  logic              valid;
  logic              ready;
  logic [SAMPW-1:0]  flex_a;
  logic [SAMPW-1:0]  flex_b;
  logic [SAMPW-1:0]  flex_c;
  logic [TOUCHW-1:0] touch_raw;

  modport source (output valid, flex_a, flex_b, flex_c, touch_raw, input ready);
  modport sink (input valid, flex_a, flex_b, flex_c, touch_raw, output ready);
endinterface

interface fts_out_if;
  import fts_pkg::*;

  logic              valid;
  logic              ready;
  logic [SAMPW-1:0]  avg_a;
  logic [SAMPW-1:0]  avg_b;
  logic [SAMPW-1:0]  avg_c;
  logic [ANGW-1:0]   angle_a;
  logic [ANGW-1:0]   angle_b;
  logic [ANGW-1:0]   angle_c;
  logic [NCH-1:0]    bent_flags;
  logic [TOUCHW-1:0] touch_voted;

  modport source (output valid, avg_a, avg_b, avg_c, angle_a, angle_b, angle_c,
                  bent_flags, touch_voted, input ready);
  modport sink (input valid, avg_a, avg_b, avg_c, angle_a, angle_b, angle_c,
                bent_flags, touch_voted, output ready);
endinterface

`default_nettype wire

// ===== sv/fts_lane.sv =====
// one flex channel: sample window, running sum, bit-serial divider, angle map
`default_nettype none

module fts_lane #(
  parameter int FLEX_WINDOW = fts_pkg::DEF_FLEX_WINDOW,
  parameter int BEND_LIMIT = 60
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fts_pkg::lane_ctl_t              ctl_i,
  input  logic [$clog2(FLEX_WINDOW)-1:0]  slot_i,
  input  logic [fts_pkg::SAMPW-1:0]       sample_i,
  input  logic [fts_pkg::SAMPW-1:0]       cal_low_i,
  input  logic [fts_pkg::SAMPW-1:0]       cal_high_i,
  output logic                            done_o,
  output logic [fts_pkg::SAMPW-1:0]       avg_o,
  output logic [fts_pkg::ANGW-1:0]        angle_o,
  output logic                            bent_o
);
  import fts_pkg::*;

  localparam int SUMW = SAMPW + $clog2(FLEX_WINDOW);
  localparam int NUMW = SAMPW + $clog2(MAX_DEG + 1);
  localparam int NW = (SUMW > NUMW) ? SUMW : NUMW;
  localparam int DVSW = ($clog2(FLEX_WINDOW + 1) > SAMPW) ? $clog2(FLEX_WINDOW + 1) : SAMPW;
  localparam int CNTW = $clog2(NW);
  localparam int DIVL = $clog2(FLEX_WINDOW);
  localparam int RSH = SUMW + DIVL;
  localparam int RCPW = SUMW + 1;
  localparam int PRODW = SUMW + RCPW;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(FLEX_WINDOW) - 64'd1) / 64'(FLEX_WINDOW);

  lane_state_e state_q, state_d;

  logic [SAMPW-1:0] win_mem [FLEX_WINDOW];
  logic [SAMPW-1:0] rd_q;
  logic [SAMPW-1:0] s_q, s_d;
  logic [SAMPW-1:0] seed_q, seed_d;
  logic             fill_q, fill_d;
  logic [SUMW-1:0]  sum_q, sum_d;
  logic [NW-1:0]    dvd_q, dvd_d;
  logic [DVSW-1:0]  rem_q, rem_d;
  logic [DVSW-1:0]  dvs_q, dvs_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [SAMPW-1:0] avg_q, avg_d;
  logic [ANGW-1:0]  angle_q, angle_d;

  logic [SAMPW-1:0] old_smp;
  logic [SUMW-1:0]  sum_new;
  logic [PRODW-1:0] prod;
  logic [SAMPW-1:0] avg_div;
  logic [DVSW:0]    shifted;
  logic [DVSW:0]    diff;
  logic             ge;
  logic [SAMPW-1:0] avg_now;
  logic [SAMPW-1:0] span;
  logic [NUMW-1:0]  num;
  logic             zero_ang;
  logic             last_step;

  // window memory: read the outgoing sample and write the new one in one beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      win_mem[slot_i] <= sample_i;
      rd_q <= win_mem[slot_i];
    end
  end

  // entries not yet written since the first item hold that item's sample
  assign old_smp = fill_q ? seed_q : rd_q;
  assign sum_new = sum_q - SUMW'(old_smp) + SUMW'(s_q);

  // divide by the window length with a reciprocal multiply, exact over the sum range
  assign prod = PRODW'(sum_q) * PRODW'(RECIP);
  assign avg_div = prod[RSH +: SAMPW];

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, dvd_q[NW-1]};
  assign diff = shifted - {1'b0, dvs_q};
  assign ge = (shifted >= {1'b0, dvs_q});
  assign last_step = (cnt_q == CNTW'(NW - 1));

  assign avg_now = dvd_q[SAMPW-1:0];
  assign span = cal_high_i - cal_low_i;
  assign num = NUMW'(avg_now - cal_low_i) * NUMW'(MAX_DEG);
  assign zero_ang = (cal_high_i <= cal_low_i) || (avg_now <= cal_low_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (ctl_i.start) state_d = L_UPD;
      L_UPD:  state_d = L_AVG;
      L_AVG:  state_d = L_MAP;
      L_MAP:  state_d = L_ANG;
      L_ANG:  if (last_step) state_d = L_FIN;
      L_FIN:  state_d = L_DONE;
      L_DONE: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    s_d = s_q;
    seed_d = seed_q;
    fill_d = fill_q;
    sum_d = sum_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    avg_d = avg_q;
    angle_d = angle_q;
    unique case (state_q)
      L_IDLE: begin
        if (ctl_i.start) begin
          s_d = sample_i;
          fill_d = ctl_i.fill;
          if (!ctl_i.seeded) begin
            seed_d = sample_i;
            sum_d = SUMW'(sample_i) * SUMW'(FLEX_WINDOW);
          end
        end
      end
      L_UPD: begin
        sum_d = sum_new;
      end
      L_AVG: begin
        dvd_d = NW'(avg_div);
      end
      L_MAP: begin
        avg_d = avg_now;
        angle_d = '0;
        // zero angle divides zero by one so every lane keeps the same timing
        dvd_d = zero_ang ? '0 : NW'(num);
        rem_d = '0;
        dvs_d = zero_ang ? DVSW'(1) : DVSW'(span);
        cnt_d = '0;
      end
      L_ANG: begin
        rem_d = ge ? diff[DVSW-1:0] : shifted[DVSW-1:0];
        dvd_d = {dvd_q[NW-2:0], ge};
        cnt_d = cnt_q + CNTW'(1);
      end
      L_FIN: begin
        angle_d = (dvd_q > NW'(MAX_DEG)) ? ANGW'(MAX_DEG) : dvd_q[ANGW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    seed_q <= seed_d;
    fill_q <= fill_d;
    sum_q <= sum_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
    avg_q <= avg_d;
    angle_q <= angle_d;
  end

  assign done_o = (state_q == L_DONE);
  assign avg_o = avg_q;
  assign angle_o = angle_q;
  assign bent_o = (angle_q > ANGW'(BEND_LIMIT));

endmodule

`default_nettype wire

// ===== sv/fts_touch_vote.sv =====
// touch pin history and per-pin majority vote
`default_nettype none

module fts_touch_vote #(
  parameter int TOUCH_WINDOW = fts_pkg::DEF_TOUCH_WINDOW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [fts_pkg::TOUCHW-1:0] touch_i,
  output logic [fts_pkg::TOUCHW-1:0] voted_o
);
  import fts_pkg::*;

  localparam int TSW = (TOUCH_WINDOW > 1) ? $clog2(TOUCH_WINDOW) : 1;
  localparam int CW = $clog2(TOUCH_WINDOW + 1);
  localparam int MAJ = TOUCH_WINDOW / 2;

  logic [TOUCHW-1:0] hist_q [TOUCH_WINDOW];
  logic [TSW-1:0]    slot_q;
  logic [TOUCH_WINDOW-1:0] col [TOUCHW];
  logic [CW-1:0]     ones [TOUCHW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TOUCH_WINDOW; j++) hist_q[j] <= '0;
      slot_q <= '0;
    end else if (take_i) begin
      hist_q[slot_q] <= touch_i;
      slot_q <= (slot_q == TSW'(TOUCH_WINDOW - 1)) ? '0 : slot_q + TSW'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < TOUCHW; c++) begin
      for (int j = 0; j < TOUCH_WINDOW; j++) col[c][j] = hist_q[j][c];
      ones[c] = CW'($countones(col[c]));
      voted_o[c] = (ones[c] > CW'(MAJ));
    end
  end

endmodule

`default_nettype wire

// ===== sv/flex_touch_sensor_conditioner.sv =====
// flex and touch sensor conditioner: three flex lanes, touch vote, result register
//
//   channel  dir  beat contents
//   in_i     in   flex_a, flex_b, flex_c, touch_raw
//   out_o    out  avg_a..c, angle_a..c, bent_flags, touch_voted
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (six calibration registers)
//
// an item is accepted only when the lanes are done with the last one; NW is the angle
// divider width (17 at the default window): each lane divides its window sum by a
// reciprocal multiply, then runs its bit-serial divider once for the angle
// every lane takes the same path, a zero angle divides zero by one
// reset clears control state, the calibration registers and the touch history; there is no clearing pass after reset
// the next item is accepted while a result still waits in the output register;
// a finished result waits in the lanes while that register is full

`default_nettype none

module flex_touch_sensor_conditioner #(
  parameter int FLEX_WINDOW = fts_pkg::DEF_FLEX_WINDOW,
  parameter int TOUCH_WINDOW = fts_pkg::DEF_TOUCH_WINDOW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fts_in_if.sink                        in_i,
  fts_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [fts_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [fts_pkg::SAMPW-1:0]     cfg_data_i
);
  import fts_pkg::*;

  localparam int FSW = $clog2(FLEX_WINDOW);

  top_state_e state_q, state_d;

  logic [SAMPW-1:0] cal_q [NREG];
  logic [FSW-1:0]   slot_q;
  logic             seeded_q;
  logic             fill_q;

  logic             in_take;
  logic             out_free;
  logic             out_load;
  logic             ready;
  lane_ctl_t        ctl;
  logic [NCH-1:0]   lane_done;
  logic [NCH-1:0]   lane_bent;
  logic [SAMPW-1:0] lane_avg [NCH];
  logic [ANGW-1:0]  lane_angle [NCH];
  logic [SAMPW-1:0] flex_s [NCH];
  logic [TOUCHW-1:0] voted;

  logic              out_valid_q;
  logic [SAMPW-1:0]  avg_q [NCH];
  logic [ANGW-1:0]   angle_q [NCH];
  logic [NCH-1:0]    bent_q;
  logic [TOUCHW-1:0] voted_q;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NREG; r++) cal_q[r] <= CAL_RESET[r];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_LOW_A:  cal_q[0] <= cfg_data_i;
        REG_CAL_HIGH_A: cal_q[1] <= cfg_data_i;
        REG_CAL_LOW_B:  cal_q[2] <= cfg_data_i;
        REG_CAL_HIGH_B: cal_q[3] <= cfg_data_i;
        REG_CAL_LOW_C:  cal_q[4] <= cfg_data_i;
        REG_CAL_HIGH_C: cal_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign in_take = in_i.valid && ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (in_take) state_d = T_CALC;
      T_CALC: if (&lane_done) state_d = out_free ? T_IDLE : T_HOLD;
      T_HOLD: if (out_free) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      T_IDLE: ready = 1'b1;
      T_CALC: out_load = (&lane_done) && out_free;
      T_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  // window slot and first-pass tracking shared by all lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      slot_q <= '0;
      seeded_q <= 1'b0;
      fill_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        seeded_q <= 1'b1;
        if (slot_q == FSW'(FLEX_WINDOW - 1)) begin
          slot_q <= '0;
          fill_q <= 1'b0;
        end else begin
          slot_q <= slot_q + FSW'(1);
        end
      end
    end
  end

  assign ctl.start = in_take;
  assign ctl.seeded = seeded_q;
  assign ctl.fill = fill_q;

  assign flex_s[0] = in_i.flex_a;
  assign flex_s[1] = in_i.flex_b;
  assign flex_s[2] = in_i.flex_c;

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    fts_lane #(
      .FLEX_WINDOW(FLEX_WINDOW),
      .BEND_LIMIT (BEND_LIMIT_TAB[g])
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .slot_i     (slot_q),
      .sample_i   (flex_s[g]),
      .cal_low_i  (cal_q[2*g]),
      .cal_high_i (cal_q[2*g+1]),
      .done_o     (lane_done[g]),
      .avg_o      (lane_avg[g]),
      .angle_o    (lane_angle[g]),
      .bent_o     (lane_bent[g])
    );
  end

  fts_touch_vote #(
    .TOUCH_WINDOW(TOUCH_WINDOW)
  ) u_touch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_take),
    .touch_i (in_i.touch_raw),
    .voted_o (voted)
  );

  // merge lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < NCH; c++) begin
        avg_q[c] <= lane_avg[c];
        angle_q[c] <= lane_angle[c];
      end
      bent_q <= lane_bent;
      voted_q <= voted;
    end
  end

  assign in_i.ready = ready;
  assign out_o.valid = out_valid_q;
  assign out_o.avg_a = avg_q[0];
  assign out_o.avg_b = avg_q[1];
  assign out_o.avg_c = avg_q[2];
  assign out_o.angle_a = angle_q[0];
  assign out_o.angle_b = angle_q[1];
  assign out_o.angle_c = angle_q[2];
  assign out_o.bent_flags = bent_q;
  assign out_o.touch_voted = voted_q;

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done != '0) |-> (lane_done == '1))
    else $error("lanes finished out of step");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done != '0) |-> (state_q == T_CALC))
    else $error("lane finished while sequencer not waiting");

  a_fill_ends_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fill_q) |-> (slot_q == '0))
    else $error("first window pass ended away from slot zero");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== bench/tb_flex_touch_sensor_conditioner.sv =====
// self-checking bench for the flex and touch conditioner: bursty samples, stalls, cal phases
`default_nettype none

module tb_flex_touch_sensor_conditioner;
  timeunit 1ns;
  timeprecision 1ps;
  import fts_pkg::*;

  localparam int FLEX_WIN = DEF_FLEX_WINDOW;
  localparam int TOUCH_WIN = DEF_TOUCH_WINDOW;
  localparam int SAMP_MAX = (1 << SAMPW) - 1;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NPHASE = 7;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;

  // indexes past the last calibration register, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam fts_reg_e LOW_REG [NCH] = '{REG_CAL_LOW_A, REG_CAL_LOW_B, REG_CAL_LOW_C};
  localparam fts_reg_e HIGH_REG [NCH] = '{REG_CAL_HIGH_A, REG_CAL_HIGH_B, REG_CAL_HIGH_C};

  typedef enum int {
    SAMPLE_UNIFORM,
    SAMPLE_EXTREME,
    SAMPLE_NEAR,
    SAMPLE_STEADY
  } sample_mode_e;

  typedef enum int {
    SINK_STREAM,
    SINK_RANDOM,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  typedef struct packed {
    logic [NCH-1:0][SAMPW-1:0] flex;
    logic [TOUCHW-1:0]         touch;
  } sensor_beat_t;

  typedef struct packed {
    logic [NCH-1:0][SAMPW-1:0] avg;
    logic [NCH-1:0][ANGW-1:0]  angle;
    logic [NCH-1:0]            bent;
    logic [TOUCHW-1:0]         voted;
  } cond_result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] idx;
    logic [SAMPW-1:0]     data;
  } reg_write_t;

  class flex_touch_scoreboard;
    logic [SAMPW-1:0]  cal_reg [NREG];
    int unsigned       flex_hist [NCH][FLEX_WIN];
    int unsigned       window_sum [NCH];
    int unsigned       flex_pos;
    bit                primed;
    logic [TOUCHW-1:0] touch_hist [TOUCH_WIN];
    int unsigned       touch_pos;
    cond_result_t      expected_q [$];
    int unsigned       mismatches;

    function new();
      cal_reg = CAL_RESET;
      foreach (flex_hist[c, j]) flex_hist[c][j] = 0;
      foreach (window_sum[c]) window_sum[c] = 0;
      foreach (touch_hist[j]) touch_hist[j] = '0;
      flex_pos = 0;
      touch_pos = 0;
      primed = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [SAMPW-1:0] data);
      if (idx < NREG) cal_reg[idx] = data;
    endfunction

    // signed division truncates toward zero, then clamp to the degree range
    function int bend_angle(int avg, int lo, int hi);
      int deg;
      if (hi <= lo) return 0;
      deg = (avg - lo) * MAX_DEG / (hi - lo);
      if (deg < 0) deg = 0;
      if (deg > MAX_DEG) deg = MAX_DEG;
      return deg;
    endfunction

    function void note_sample(sensor_beat_t beat);
      cond_result_t res;
      int unsigned  s;
      int unsigned  avg;
      int           ang;
      int           ones;
      int           c;
      int           j;
      res = '0;
      for (c = 0; c < NCH; c++) begin
        s = beat.flex[c];
        // first beat after reset fills the whole window with its own sample
        if (!primed) begin
          for (j = 0; j < FLEX_WIN; j++) flex_hist[c][j] = s;
          window_sum[c] = s * FLEX_WIN;
        end
        window_sum[c] = window_sum[c] - flex_hist[c][flex_pos] + s;
        flex_hist[c][flex_pos] = s;
        avg = window_sum[c] / FLEX_WIN;
        ang = bend_angle(int'(avg), int'(cal_reg[LOW_REG[c]]), int'(cal_reg[HIGH_REG[c]]));
        res.avg[c] = avg[SAMPW-1:0];
        res.angle[c] = ang[ANGW-1:0];
        res.bent[c] = (ang > BEND_LIMIT_TAB[c]);
      end
      primed = 1'b1;
      flex_pos = (flex_pos + 1) % FLEX_WIN;

      touch_hist[touch_pos] = beat.touch;
      touch_pos = (touch_pos + 1) % TOUCH_WIN;
      for (c = 0; c < TOUCHW; c++) begin
        ones = 0;
        for (j = 0; j < TOUCH_WIN; j++) ones += touch_hist[j][c];
        res.voted[c] = (ones > TOUCH_WIN / 2);
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t ns mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(cond_result_t got);
      cond_result_t want;
      int           c;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns unexpected result beat: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      for (c = 0; c < NCH; c++) begin
        compare_field($sformatf("avg[%0d]", c), 16'(want.avg[c]), 16'(got.avg[c]));
        compare_field($sformatf("angle[%0d]", c), 16'(want.angle[c]), 16'(got.angle[c]));
      end
      compare_field("bent_flags", 16'(want.bent), 16'(got.bent));
      compare_field("touch_voted", 16'(want.voted), 16'(got.voted));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [SAMPW-1:0]     cfg_data_i;
  logic                 hold_req;
  int unsigned          cycle_count;

  flex_touch_scoreboard sb;
  reg_write_t           cal_writes [$];

  fts_in_if  sensor_if ();
  fts_out_if cond_if ();

  flex_touch_sensor_conditioner #(
    .FLEX_WINDOW(FLEX_WIN),
    .TOUCH_WINDOW(TOUCH_WIN)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(sensor_if),
    .out_o(cond_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check every accepted beat, stall on a pattern of its own
  initial begin : result_sink
    sink_mode_e   stall_mode;
    int           mode_left;
    int           hold_left;
    bit           hold_done;
    cond_result_t got;
    stall_mode = SINK_STREAM;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    cond_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cond_if.valid && cond_if.ready) begin
        got.avg[0] = cond_if.avg_a;
        got.avg[1] = cond_if.avg_b;
        got.avg[2] = cond_if.avg_c;
        got.angle[0] = cond_if.angle_a;
        got.angle[1] = cond_if.angle_b;
        got.angle[2] = cond_if.angle_c;
        got.bent = cond_if.bent_flags;
        got.voted = cond_if.touch_voted;
        sb.check_result(got);
      end
      if (mode_left == 0) begin
        stall_mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        cond_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long back-pressure so the block fills up and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        cond_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          SINK_STREAM: cond_if.ready <= 1'b1;
          SINK_RANDOM: cond_if.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: cond_if.ready <= ($urandom_range(0, 3) == 0);
          default:     cond_if.ready <= cycle_count[2];
        endcase
      end
    end
  end

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > SAMP_MAX) return SAMP_MAX;
    return v;
  endfunction

  // sample around the calibrated range of a channel so angles land in 0..90
  function automatic int near_sample(int c);
    int lo;
    int hi;
    lo = sb.cal_reg[LOW_REG[c]];
    hi = sb.cal_reg[HIGH_REG[c]];
    if (lo > hi) begin
      lo = sb.cal_reg[HIGH_REG[c]];
      hi = sb.cal_reg[LOW_REG[c]];
    end
    return $urandom_range(clamp_sample(lo - 48), clamp_sample(hi + 48));
  endfunction

  function automatic sensor_beat_t mk_beat(int a, int b, int c, int t);
    sensor_beat_t beat;
    beat.flex[0] = a[SAMPW-1:0];
    beat.flex[1] = b[SAMPW-1:0];
    beat.flex[2] = c[SAMPW-1:0];
    beat.touch = t[TOUCHW-1:0];
    return beat;
  endfunction

  function automatic void add_cal(int c, int lo, int hi);
    cal_writes.push_back('{idx: LOW_REG[c], data: lo[SAMPW-1:0]});
    cal_writes.push_back('{idx: HIGH_REG[c], data: hi[SAMPW-1:0]});
  endfunction

  task automatic send_beat(sensor_beat_t beat);
    sensor_if.valid <= 1'b1;
    sensor_if.flex_a <= beat.flex[0];
    sensor_if.flex_b <= beat.flex[1];
    sensor_if.flex_c <= beat.flex[2];
    sensor_if.touch_raw <= beat.touch;
    do @(posedge clk_i); while (!sensor_if.ready);
    sb.note_sample(beat);
  endtask

  task automatic idle_gap(int n);
    sensor_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic program_regs();
    foreach (cal_writes[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cal_writes[i].idx;
      cfg_data_i <= cal_writes[i].data;
      @(posedge clk_i);
      sb.write_reg(cal_writes[i].idx, cal_writes[i].data);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cal_writes = {};
  endtask

  // wait for every expected beat, then let the block settle before a cal write
  task automatic finish_phase();
    sensor_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_traffic(int n);
    int                sent;
    int                burst;
    int                k;
    int                c;
    int                jitter;
    int                base [NCH];
    int                pick;
    sample_mode_e      mode;
    bit                touch_steady;
    logic [TOUCHW-1:0] touch_level;
    sensor_beat_t      beat;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      pick = $urandom_range(0, 7);
      mode = (pick == 0) ? SAMPLE_UNIFORM : (pick == 1) ? SAMPLE_EXTREME :
             (pick < 5) ? SAMPLE_NEAR : SAMPLE_STEADY;
      touch_steady = 1'($urandom_range(0, 1));
      touch_level = TOUCHW'($urandom_range(0, 7));
      for (c = 0; c < NCH; c++) base[c] = near_sample(c);
      for (k = 0; k < burst && sent < n; k++) begin
        for (c = 0; c < NCH; c++) begin
          case (mode)
            SAMPLE_UNIFORM: beat.flex[c] = SAMPW'($urandom_range(0, SAMP_MAX));
            SAMPLE_EXTREME: beat.flex[c] = $urandom_range(0, 1) ? SAMPW'(SAMP_MAX) : '0;
            SAMPLE_NEAR:    beat.flex[c] = SAMPW'(near_sample(c));
            default: begin
              jitter = $urandom_range(0, 14);
              beat.flex[c] = SAMPW'(clamp_sample(base[c] + jitter - 7));
            end
          endcase
        end
        // bouncing contact: a steady level with the odd flipped bit
        if (touch_steady) begin
          if ($urandom_range(0, 5) == 0) touch_level[$urandom_range(0, TOUCHW - 1)] ^= 1'b1;
          beat.touch = touch_level;
        end else begin
          beat.touch = TOUCHW'($urandom_range(0, 7));
        end
        send_beat(beat);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    sensor_beat_t directed_q [$];
    int           c;
    int           p;
    int           i;
    int           lo;
    int           hi;
    sb = new();
    rst_ni <= 1'b0;
    hold_req <= 1'b0;
    sensor_if.valid <= 1'b0;
    sensor_if.flex_a <= '0;
    sensor_if.flex_b <= '0;
    sensor_if.flex_c <= '0;
    sensor_if.touch_raw <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed beat at full scale, then extremes, bit patterns and cal corners
    directed_q.push_back(mk_beat(SAMP_MAX, SAMP_MAX, SAMP_MAX, 7));
    directed_q.push_back(mk_beat(0, 0, 0, 0));
    directed_q.push_back(mk_beat(0, 0, 0, 7));
    directed_q.push_back(mk_beat(SAMP_MAX, SAMP_MAX, SAMP_MAX, 5));
    directed_q.push_back(mk_beat(SAMP_MAX, SAMP_MAX, SAMP_MAX, 2));
    directed_q.push_back(mk_beat('h155, 'h2aa, 'h155, 1));
    directed_q.push_back(mk_beat('h2aa, 'h155, 'h2aa, 6));
    directed_q.push_back(mk_beat(900, 850, 890, 3));
    directed_q.push_back(mk_beat(1023, 960, 965, 4));
    directed_q.push_back(mk_beat(960, 905, 927, 0));
    for (i = 0; i < 9; i++) directed_q.push_back(mk_beat(SAMP_MAX, SAMP_MAX, SAMP_MAX, i));
    for (i = 0; i < 5; i++) directed_q.push_back(mk_beat(0, 0, 0, 7 - i));
    foreach (directed_q[j]) send_beat(directed_q[j]);
    finish_phase();

    for (p = 0; p < NPHASE; p++) begin
      case (p)
        0: ;
        1: begin
          for (c = 0; c < NCH; c++) add_cal(c, 0, SAMP_MAX);
          cal_writes.push_back('{idx: REG_SPARE_LO, data: '1});
          cal_writes.push_back('{idx: REG_SPARE_HI, data: '0});
        end
        2: begin
          // empty ranges: inverted, equal, off by one
          add_cal(0, SAMP_MAX, 0);
          add_cal(1, 512, 512);
          add_cal(2, 1000, 999);
          cal_writes.push_back('{idx: REG_SPARE_LO, data: 10'h2aa});
          cal_writes.push_back('{idx: REG_SPARE_HI, data: 10'h155});
        end
        3: begin
          add_cal(0, 500, 501);
          add_cal(1, 0, 1);
          add_cal(2, SAMP_MAX - 1, SAMP_MAX);
        end
        default: begin
          for (c = 0; c < NCH; c++) begin
            lo = $urandom_range(0, SAMP_MAX - 1);
            if ($urandom_range(0, 5) == 0) hi = $urandom_range(0, lo);
            else hi = lo + $urandom_range(1, SAMP_MAX - lo);
            add_cal(c, lo, hi);
          end
        end
      endcase
      program_regs();
      if (p == 1) hold_req <= 1'b1;
      random_traffic(ITEMS_PER_PHASE);
      finish_phase();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/fts_pkg.sv
sv/fts_if.sv
sv/fts_lane.sv
sv/fts_touch_vote.sv
sv/flex_touch_sensor_conditioner.sv
bench/tb_flex_touch_sensor_conditioner.sv
